>>> hdl/tdk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_pkg
// Shared widths, constants, register indexes and the square-root step for
// the triangle depth key pipeline.
// ----------------------------------------------------------------------------
package tdk_pkg;

    // Register indexes of the configuration port.
    localparam logic [3:0] CFG_COL_X_XY = 4'd0;
    localparam logic [3:0] CFG_COL_Y_XY = 4'd1;
    localparam logic [3:0] CFG_COL_Z_XY = 4'd2;
    localparam logic [3:0] CFG_TRANS_XY = 4'd3;
    localparam logic [3:0] CFG_ROW_Z_XY = 4'd4;
    localparam logic [3:0] CFG_ROW_Z_ZT = 4'd5;
    localparam logic [3:0] CFG_CAMERA_XY = 4'd6;
    localparam logic [3:0] CFG_CAMERA_Z = 4'd7;

    // One third in Q0.16 (16 fraction bits).
    localparam logic signed [15:0] ONE_THIRD_Q16 = 16'sh5555;

    // Square root: 32 result bits, two bits per stage.
    localparam int SQRT_BITS      = 32;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = SQRT_BITS / SQRT_PER_STAGE;

    // Transform (2) + centroid (2) + distance (2) + root stages.
    localparam int LAT = 6 + SQRT_STAGES;

    // Working state of the digit-by-digit square root.
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sqrt;

    // One result bit of the restoring square root.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt      r;
        logic [35:0] t;
        logic [35:0] trial;
        t     = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        r.rad = {s.rad[61:0], 2'b00};
        if (t >= trial) begin
            r.rem  = 34'(t - trial);
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = t[33:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/triangle_depth_key_top.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes the transform, centroid, distance and root stages in turn.
// Throughput: one item per cycle while the output is not stalled; the 16-stage square root sets the depth.
// Reset: synchronous, active low; clears all valid bits and the configuration registers.
// Output stall holds the whole pipeline; bubbles do not hold it.
// ----------------------------------------------------------------------------
// triangle_depth_key_top
// Transforms three vertices, averages them, and emits the camera distance
// of the centroid with the triangle number as a depth-sort key.
// ----------------------------------------------------------------------------
module triangle_depth_key_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_tri_index,
    input  wire logic [31:0] i_a_x,
    input  wire logic [31:0] i_a_y,
    input  wire logic [31:0] i_a_z,
    input  wire logic [31:0] i_b_x,
    input  wire logic [31:0] i_b_y,
    input  wire logic [31:0] i_b_z,
    input  wire logic [31:0] i_c_x,
    input  wire logic [31:0] i_c_y,
    input  wire logic [31:0] i_c_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_key_index,
    output logic [31:0]      o_distance,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0] r_cfg [8];
    logic [tdk_pkg::LAT-1:0] r_vld;
    logic [15:0] r_idx [tdk_pkg::LAT];
    logic        n_en;
    logic signed [31:0] n_vx [3][3];
    logic signed [31:0] n_mat [3][4];
    logic signed [31:0] n_w [3][3];
    logic signed [31:0] n_cen [3];
    logic [63:0] n_sq;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_cfg[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tdk_pkg::CFG_COL_X_XY: r_cfg[0] <= i_cfg_data;
                tdk_pkg::CFG_COL_Y_XY: r_cfg[1] <= i_cfg_data;
                tdk_pkg::CFG_COL_Z_XY: r_cfg[2] <= i_cfg_data;
                tdk_pkg::CFG_TRANS_XY: r_cfg[3] <= i_cfg_data;
                tdk_pkg::CFG_ROW_Z_XY: r_cfg[4] <= i_cfg_data;
                tdk_pkg::CFG_ROW_Z_ZT: r_cfg[5] <= i_cfg_data;
                tdk_pkg::CFG_CAMERA_XY: r_cfg[6] <= i_cfg_data;
                tdk_pkg::CFG_CAMERA_Z: r_cfg[7] <= {32'd0, i_cfg_data[31:0]};
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a finished item waits at the output.
    assign n_en    = !(r_vld[tdk_pkg::LAT-1] && i_stall);
    assign o_stall = !n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[tdk_pkg::LAT-2:0], i_valid};
        end
    end

    // Triangle number travels beside the data.
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_idx[0] <= i_tri_index;
            for (int i = 1; i < tdk_pkg::LAT; i++) r_idx[i] <= r_idx[i-1];
        end
    end

    // Vertex and matrix unpacking: rows x, y, z; columns x, y, z, translation.
    always_comb begin
        n_vx[0] = '{i_a_x, i_a_y, i_a_z};
        n_vx[1] = '{i_b_x, i_b_y, i_b_z};
        n_vx[2] = '{i_c_x, i_c_y, i_c_z};
        n_mat[0] = '{r_cfg[0][31:0], r_cfg[1][31:0], r_cfg[2][31:0], r_cfg[3][31:0]};
        n_mat[1] = '{r_cfg[0][63:32], r_cfg[1][63:32], r_cfg[2][63:32],
                     r_cfg[3][63:32]};
        n_mat[2] = '{r_cfg[4][31:0], r_cfg[4][63:32], r_cfg[5][31:0], r_cfg[5][63:32]};
    end

    for (genvar v = 0; v < 3; v++) begin : g_vert
        for (genvar r = 0; r < 3; r++) begin : g_row
            tdk_xform u_xform (
                .i_clk (i_clk),
                .i_en  (n_en),
                .i_x   (n_vx[v][0]),
                .i_y   (n_vx[v][1]),
                .i_z   (n_vx[v][2]),
                .i_m0  (n_mat[r][0]),
                .i_m1  (n_mat[r][1]),
                .i_m2  (n_mat[r][2]),
                .i_t   (n_mat[r][3]),
                .o_w   (n_w[v][r])
            );
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        tdk_centroid u_cen (
            .i_clk (i_clk),
            .i_en  (n_en),
            .i_a   (n_w[0][k]),
            .i_b   (n_w[1][k]),
            .i_c   (n_w[2][k]),
            .o_cen (n_cen[k])
        );
    end

    tdk_dist u_dist (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_cen_x (n_cen[0]),
        .i_cen_y (n_cen[1]),
        .i_cen_z (n_cen[2]),
        .i_cam_x (r_cfg[6][31:0]),
        .i_cam_y (r_cfg[6][63:32]),
        .i_cam_z (r_cfg[7][31:0]),
        .o_sq    (n_sq)
    );

    tdk_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_rad  (n_sq),
        .o_root (o_distance)
    );

    assign o_valid     = r_vld[tdk_pkg::LAT-1];
    assign o_key_index = r_idx[tdk_pkg::LAT-1];

    // An accepted item enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    // With no output stall, the last internal item reaches the output.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall && r_vld[tdk_pkg::LAT-2] |=> o_valid)
        else $error("item lost before output");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

>>> hdl/tdk_xform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_xform
// One matrix row applied to one vertex: three products, then a floored
// shift, the translation and a saturating narrow to 32 bits.
// ----------------------------------------------------------------------------
module tdk_xform (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_y,
    input  wire logic signed [31:0] i_z,
    input  wire logic signed [31:0] i_m0,
    input  wire logic signed [31:0] i_m1,
    input  wire logic signed [31:0] i_m2,
    input  wire logic signed [31:0] i_t,
    output logic signed [31:0]      o_w
);
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic signed [50:0] n_sum;
    logic signed [31:0] n_w;

    // Products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_m0 * i_x;
            r_p1 <= i_m1 * i_y;
            r_p2 <= i_m2 * i_z;
        end
    end

    // Arithmetic shift is a floor; sum is exact in 51 bits.
    always_comb begin
        n_sum = 51'(r_p0 >>> 16) + 51'(r_p1 >>> 16) + 51'(r_p2 >>> 16) + 51'(i_t);
        if (n_sum > 51'sd2147483647) begin
            n_w = 32'sh7FFFFFFF;
        end else if (n_sum < -51'sd2147483648) begin
            n_w = 32'sh80000000;
        end else begin
            n_w = n_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= n_w;
        end
    end
endmodule
`default_nettype wire

>>> hdl/tdk_centroid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_centroid
// One centroid coordinate: sum of three world coordinates times one third.
// ----------------------------------------------------------------------------
module tdk_centroid (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic signed [31:0] i_c,
    output logic signed [31:0]      o_cen
);
    logic signed [33:0] r_sum;
    logic signed [49:0] n_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= 34'(i_a) + 34'(i_b) + 34'(i_c);
        end
    end

    // The scaled sum always fits 32 bits after the floored shift.
    assign n_prod = r_sum * tdk_pkg::ONE_THIRD_Q16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cen <= n_prod[47:16];
        end
    end
endmodule
`default_nettype wire

>>> hdl/tdk_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_dist
// Squared camera distance: per-axis squares, then a sum saturated at 64 bits.
// ----------------------------------------------------------------------------
module tdk_dist (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_cen_x,
    input  wire logic signed [31:0] i_cen_y,
    input  wire logic signed [31:0] i_cen_z,
    input  wire logic signed [31:0] i_cam_x,
    input  wire logic signed [31:0] i_cam_y,
    input  wire logic signed [31:0] i_cam_z,
    output logic [63:0]             o_sq
);
    logic signed [32:0] n_dx, n_dy, n_dz;
    logic [31:0]        n_ax, n_ay, n_az;
    logic [63:0]        r_sx, r_sy, r_sz;
    logic [65:0]        n_tot;

    // Differences are exact; magnitudes fit 32 bits.
    always_comb begin
        n_dx = 33'(i_cam_x) - 33'(i_cen_x);
        n_dy = 33'(i_cam_y) - 33'(i_cen_y);
        n_dz = 33'(i_cam_z) - 33'(i_cen_z);
        n_ax = n_dx[32] ? 32'(-n_dx) : n_dx[31:0];
        n_ay = n_dy[32] ? 32'(-n_dy) : n_dy[31:0];
        n_az = n_dz[32] ? 32'(-n_dz) : n_dz[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= 64'(n_ax) * 64'(n_ax);
            r_sy <= 64'(n_ay) * 64'(n_ay);
            r_sz <= 64'(n_az) * 64'(n_az);
        end
    end

    // Saturating sum.
    assign n_tot = 66'(r_sx) + 66'(r_sy) + 66'(r_sz);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sq <= (n_tot[65:64] != 2'b00) ? '1 : n_tot[63:0];
        end
    end
endmodule
`default_nettype wire

>>> hdl/tdk_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_isqrt
// Pipelined floor square root of a 64-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module tdk_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_rad,
    output logic [31:0]      o_root
);
    tdk_pkg::t_sqrt r_st [tdk_pkg::SQRT_STAGES];
    tdk_pkg::t_sqrt n_st [tdk_pkg::SQRT_STAGES];
    tdk_pkg::t_sqrt n_in;

    assign n_in = '{rad: i_rad, rem: '0, root: '0};

    // Each stage resolves its share of the result bits.
    always_comb begin
        n_st[0] = n_in;
        for (int j = 0; j < tdk_pkg::SQRT_PER_STAGE; j++) begin
            n_st[0] = tdk_pkg::sqrt_step(n_st[0]);
        end
        for (int s = 1; s < tdk_pkg::SQRT_STAGES; s++) begin
            n_st[s] = r_st[s-1];
            for (int j = 0; j < tdk_pkg::SQRT_PER_STAGE; j++) begin
                n_st[s] = tdk_pkg::sqrt_step(n_st[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_root = r_st[tdk_pkg::SQRT_STAGES-1].root;
endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams triangles into the depth key block under several matrix and camera
// settings, with random sender bursts and receiver stalls. Each accepted item
// is run through a local fixed-point model and the keys are compared in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  RANDOM_ITEMS  = 700;
    localparam logic [3:0] CFG_NONE_FIRST = 4'd8;
    localparam logic [3:0] CFG_NONE_LAST  = 4'd15;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;

    typedef struct {
        logic [15:0] tri_index;
        logic [31:0] vert [9];
    } t_tri;

    typedef struct {
        logic [15:0] key_index;
        logic [31:0] distance;
    } t_key;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_tri_index;
    logic [31:0] i_vert [9];
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_key_index;
    logic [31:0] o_distance;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    t_tri  pending_tris [$];
    t_key  expected_keys [$];
    logic [63:0] xform_regs [8];
    int    mismatches;
    int    cycles;
    int    stall_pct;
    int    gap_left;
    int    burst_left;
    logic  taken;

    triangle_depth_key_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_tri_index(i_tri_index),
        .i_a_x(i_vert[0]), .i_a_y(i_vert[1]), .i_a_z(i_vert[2]),
        .i_b_x(i_vert[3]), .i_b_y(i_vert[4]), .i_b_z(i_vert[5]),
        .i_c_x(i_vert[6]), .i_c_y(i_vert[7]), .i_c_z(i_vert[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_key_index(o_key_index), .o_distance(o_distance),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Signed Q16.16 word to a wide signed value.
    function automatic longint sw(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // One matrix row applied to a vertex, saturated to signed 32 bits.
    function automatic longint world_coord(input logic [31:0] m0, input logic [31:0] m1,
                                           input logic [31:0] m2, input logic [31:0] t,
                                           input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
        longint s;
        s = ((sw(m0) * sw(x)) >>> 16) + ((sw(m1) * sw(y)) >>> 16)
            + ((sw(m2) * sw(z)) >>> 16) + sw(t);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    // Expected depth key of one triangle under the current registers.
    function automatic t_key depth_key(input t_tri tr);
        t_key        k;
        longint      sum [3];
        longint      d;
        logic [63:0] mag;
        logic [65:0] sq_sum;
        logic [63:0] rad;
        logic [31:0] root;
        logic [31:0] trial;
        sum[0] = 0; sum[1] = 0; sum[2] = 0;
        sq_sum = '0;
        for (int v = 0; v < 3; v++) begin
            sum[0] += world_coord(xform_regs[0][31:0], xform_regs[1][31:0],
                xform_regs[2][31:0], xform_regs[3][31:0],
                tr.vert[3*v], tr.vert[3*v+1], tr.vert[3*v+2]);
            sum[1] += world_coord(xform_regs[0][63:32], xform_regs[1][63:32],
                xform_regs[2][63:32], xform_regs[3][63:32],
                tr.vert[3*v], tr.vert[3*v+1], tr.vert[3*v+2]);
            sum[2] += world_coord(xform_regs[4][31:0], xform_regs[4][63:32],
                xform_regs[5][31:0], xform_regs[5][63:32],
                tr.vert[3*v], tr.vert[3*v+1], tr.vert[3*v+2]);
        end
        // Centroid, then squared distance to the camera, saturating.
        for (int a = 0; a < 3; a++) begin
            sum[a] = (sum[a] * 21845) >>> 16;
            case (a)
                0: d = sw(xform_regs[6][31:0]) - sum[a];
                1: d = sw(xform_regs[6][63:32]) - sum[a];
                default: d = sw(xform_regs[7][31:0]) - sum[a];
            endcase
            mag = (d < 0) ? 64'(-d) : 64'(d);
            sq_sum += 66'(mag * mag);
        end
        rad = (sq_sum[65:64] != 2'b00) ? '1 : sq_sum[63:0];
        // Integer square root, one result bit at a time.
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= rad) root = trial;
        end
        k.key_index = tr.tri_index;
        k.distance  = root;
        return k;
    endfunction

    // Item driver: bursts of items with random gaps, payload held while stalled.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || taken)) begin
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_tris.size() > 0) begin
                t_tri tr;
                tr = pending_tris.pop_front();
                i_valid     <= 1'b1;
                i_tri_index <= tr.tri_index;
                i_vert      <= tr.vert;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Acceptance on the input side and checking on the output side.
    always @(posedge i_clk) begin
        taken <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            t_tri tr;
            tr.tri_index = i_tri_index;
            tr.vert      = i_vert;
            expected_keys.push_back(depth_key(tr));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_keys.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected key: index %h distance %h", o_key_index, o_distance);
            end else begin
                t_key e;
                e = expected_keys.pop_front();
                if (e.key_index !== o_key_index || e.distance !== o_distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("key mismatch: expected index %h distance %h, got %h %h",
                            e.key_index, e.distance, o_key_index, o_distance);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Register write while idle; the local copy follows the block.
    task automatic write_reg(input logic [3:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx <= tdk_pkg::CFG_CAMERA_Z)
            xform_regs[idx] = (idx == tdk_pkg::CFG_CAMERA_Z) ? {32'd0, data[31:0]} : data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_setting(input logic [63:0] r [8]);
        write_reg(tdk_pkg::CFG_COL_X_XY, r[0]);
        write_reg(tdk_pkg::CFG_COL_Y_XY, r[1]);
        write_reg(tdk_pkg::CFG_COL_Z_XY, r[2]);
        write_reg(tdk_pkg::CFG_TRANS_XY, r[3]);
        write_reg(tdk_pkg::CFG_ROW_Z_XY, r[4]);
        write_reg(tdk_pkg::CFG_ROW_Z_ZT, r[5]);
        write_reg(tdk_pkg::CFG_CAMERA_XY, r[6]);
        write_reg(tdk_pkg::CFG_CAMERA_Z, r[7]);
        write_reg(4'($urandom_range(CFG_NONE_FIRST, CFG_NONE_LAST)), {$urandom, $urandom});
    endtask

    // Waits until every item has been sent, every key has come back and the
    // pipeline has drained.
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_tris.size() != 0 || expected_keys.size() != 0
                   || i_valid || o_valid);
        repeat (tdk_pkg::LAT + 8) @(negedge i_clk);
    endtask

    function automatic t_tri make_tri(input int shape);
        t_tri tr;
        tr.tri_index = 16'($urandom);
        for (int i = 0; i < 9; i++) begin
            case (shape)
                0: tr.vert[i] = $urandom;
                1: tr.vert[i] = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
                default: tr.vert[i] = ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
            endcase
        end
        return tr;
    endfunction

    function automatic logic [31:0] rand_entry(input bit narrow);
        if (narrow)
            return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        return $urandom;
    endfunction

    // Stimulus: directed triangles, then random phases over several settings.
    initial begin
        logic [63:0] setting [8];
        t_tri tr;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_tri_index = '0;
        for (int i = 0; i < 9; i++) i_vert[i] = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        stall_pct = 0;
        gap_left = 0;
        burst_left = 1;
        taken = 1'b0;
        for (int i = 0; i < 8; i++) xform_regs[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Registers at reset: every key is the camera distance of the origin.
        for (int i = 0; i < 4; i++) pending_tris.push_back(make_tri(i % 3));
        drain();

        // Identity matrix, camera at the origin; field extremes.
        setting = '{{32'd0, Q_ONE}, {Q_ONE, 32'd0}, 64'd0, 64'd0, 64'd0,
                    {32'd0, Q_ONE}, 64'd0, 64'd0};
        load_setting(setting);
        tr.tri_index = 16'h0000;
        for (int i = 0; i < 9; i++) tr.vert[i] = '0;
        pending_tris.push_back(tr);
        tr.tri_index = 16'hFFFF;
        for (int i = 0; i < 9; i++) tr.vert[i] = Q_MAX;
        pending_tris.push_back(tr);
        for (int i = 0; i < 9; i++) tr.vert[i] = Q_MIN;
        pending_tris.push_back(tr);
        for (int i = 0; i < 9; i++) tr.vert[i] = (i % 3 == 0) ? Q_ONE : 32'hFFFF_FFFF;
        pending_tris.push_back(tr);
        for (int i = 0; i < 6; i++) pending_tris.push_back(make_tri(i % 3));
        drain();

        // Huge matrix and translation: world coordinates saturate.
        setting = '{{Q_MAX, Q_MAX}, {Q_MIN, Q_MIN}, {Q_MAX, Q_MIN}, {Q_MAX, Q_MIN},
                    {Q_MIN, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MIN, Q_MAX}, {32'd0, Q_MIN}};
        load_setting(setting);
        stall_pct = 30;
        for (int i = 0; i < 10; i++) pending_tris.push_back(make_tri(i % 3));
        drain();

        // Camera at the far corner: sums of squares beyond range saturate.
        setting = '{{Q_MIN, Q_MAX}, {Q_MIN, Q_MAX}, {Q_MIN, Q_MAX}, {Q_MIN, Q_MAX},
                    {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_MAX, Q_MIN}, {32'd0, Q_MAX}};
        load_setting(setting);
        for (int i = 0; i < 6; i++) pending_tris.push_back(make_tri(i % 3));
        drain();

        // Random settings, mostly plausible transforms with some wild ones.
        for (int ph = 0; ph < 7; ph++) begin
            for (int i = 0; i < 8; i++)
                setting[i] = {rand_entry(ph % 3 != 0), rand_entry(ph % 3 != 0)};
            load_setting(setting);
            stall_pct = (ph == 2) ? 0 : (ph == 5) ? 85 : $urandom_range(5, 60);
            for (int i = 0; i < RANDOM_ITEMS / 7; i++)
                pending_tris.push_back(make_tri(($urandom_range(0, 9) < 6) ? 1 :
                    ($urandom_range(0, 4) == 0) ? 2 : 0));
            drain();
        end

        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tdk_pkg.sv
hdl/tdk_xform.sv
hdl/tdk_centroid.sv
hdl/tdk_dist.sv
hdl/tdk_isqrt.sv
hdl/triangle_depth_key_top.sv
test/testbench.sv
